// File: sv/ute_pkg.sv
// Shared types and constants for the UTF-16 to UTF-8 encoder.
`timescale 1ns / 1ps

package ute_pkg;

    // Most bytes one code unit can produce: a flushed high surrogate plus a three-byte unit
    localparam int BurstMax = 6;
    localparam int CntW     = 3;
    localparam int UnitW    = 16;

    // Surrogate ranges and encoding marks
    localparam logic [UnitW-1:0] HighFirst = 16'hd800;
    localparam logic [UnitW-1:0] HighLast  = 16'hdbff;
    localparam logic [UnitW-1:0] LowFirst  = 16'hdc00;
    localparam logic [UnitW-1:0] LowLast   = 16'hdfff;
    localparam logic [UnitW-1:0] OneByteMax = 16'h007f;
    localparam logic [UnitW-1:0] TwoByteMax = 16'h07ff;
    localparam logic [20:0]      SuppBase  = 21'h10000;

    localparam logic [7:0] LeadTwo   = 8'hc0;
    localparam logic [7:0] LeadThree = 8'he0;
    localparam logic [7:0] LeadFour  = 8'hf0;
    localparam logic [7:0] ContMark  = 8'h80;

    typedef logic [7:0] byte_t;

    // Bytes produced by one item, in stream order, and how many are valid
    typedef struct packed {
        logic [BurstMax-1:0][7:0] bytes;
        logic [CntW-1:0]          cnt;
    } burst_t;

endpackage

// File: sv/utf16_to_utf8_encoder_top.sv
// Top level of the UTF-16 to UTF-8 encoder.
`timescale 1ns / 1ps
// Usage:
//   Input channel: code_unit and last_unit with in_valid / in_stall. One item is one
//   UTF-16 code unit; last_unit closes a string and flushes a held high surrogate.
//   Output channel: out_byte and run_end with out_valid / out_stall, one UTF-8 byte
//   per item; run_end marks the last byte caused by one input unit.
// An accepted item is loaded into the burst register, then its bytes pass to the output.
// Throughput: while out_stall is low, the output register moves one byte per cycle. A unit
//   yields 1 to 3 bytes typically, 4 for a surrogate pair, up to 6 when a held high
//   surrogate is flushed ahead of a three-byte unit. A high surrogate that is held
//   yields nothing.
// A new item is taken in the same cycle the last byte of the previous one moves to
//   the output register, so units flow without gaps.
// Reset clears the held surrogate and empties both the burst and output registers.
// While out_stall is high a valid output byte holds; once the burst register is full,
//   in_stall rises until its last byte moves out.

module utf16_to_utf8_encoder_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [ute_pkg::UnitW-1:0] code_unit,
    input  logic                      last_unit,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [7:0]                out_byte,
    output logic                      run_end
);

    logic            take;
    logic            busy;
    ute_pkg::burst_t burst;

    // Item accepted when the burst register is free or freeing
    assign in_stall = busy;
    assign take     = in_valid && !busy;

    ute_encode u_encode (
        .clk       (clk),
        .rst_n     (rst_n),
        .code_unit (code_unit),
        .last_unit (last_unit),
        .take      (take),
        .burst     (burst)
    );

    ute_serial u_serial (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .burst     (burst),
        .busy      (busy),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .run_end   (run_end)
    );

endmodule

// File: sv/ute_encode.sv
// Encoder stage: held-surrogate state and the per-item UTF-8 byte burst.
`timescale 1ns / 1ps

module ute_encode (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [ute_pkg::UnitW-1:0]   code_unit,
    input  logic                        last_unit,
    input  logic                        take,
    output ute_pkg::burst_t             burst
);

    logic [ute_pkg::UnitW-1:0] held_high_reg;
    logic [ute_pkg::UnitW-1:0] held_high_next;
    logic                      held_valid_reg;
    logic                      held_valid_next;

    logic                      u_high;
    logic                      u_low;
    logic                      pair;
    logic [20:0]               cp;
    logic [2:0][7:0]           held_b;
    logic [2:0][7:0]           unit_b;
    logic [ute_pkg::CntW-1:0]  unit_cnt;
    logic                      unit_hold;

    // Surrogate classification
    assign u_high = (code_unit >= ute_pkg::HighFirst) && (code_unit <= ute_pkg::HighLast);
    assign u_low  = (code_unit >= ute_pkg::LowFirst) && (code_unit <= ute_pkg::LowLast);
    assign pair   = held_valid_reg && u_low;

    // Supplementary code point from the surrogate pair
    assign cp = {1'b0, held_high_reg[9:0], code_unit[9:0]} + ute_pkg::SuppBase;

    // Held high surrogate flushed as three bytes
    assign held_b[0] = ute_pkg::LeadThree | {4'd0, held_high_reg[15:12]};
    assign held_b[1] = ute_pkg::ContMark | {2'd0, held_high_reg[11:6]};
    assign held_b[2] = ute_pkg::ContMark | {2'd0, held_high_reg[5:0]};

    // Bytes for the current unit on its own
    always_comb
    begin
        unit_b    = '0;
        unit_cnt  = '0;
        unit_hold = 1'b0;
        if (code_unit == '0)
        begin
            unit_b[0] = ute_pkg::LeadTwo;
            unit_b[1] = ute_pkg::ContMark;
            unit_cnt  = ute_pkg::CntW'(2);
        end
        else if (code_unit <= ute_pkg::OneByteMax)
        begin
            unit_b[0] = code_unit[7:0];
            unit_cnt  = ute_pkg::CntW'(1);
        end
        else if (code_unit <= ute_pkg::TwoByteMax)
        begin
            unit_b[0] = ute_pkg::LeadTwo | {3'd0, code_unit[10:6]};
            unit_b[1] = ute_pkg::ContMark | {2'd0, code_unit[5:0]};
            unit_cnt  = ute_pkg::CntW'(2);
        end
        else if (u_high && !last_unit)
        begin
            unit_hold = 1'b1;
        end
        else
        begin
            unit_b[0] = ute_pkg::LeadThree | {4'd0, code_unit[15:12]};
            unit_b[1] = ute_pkg::ContMark | {2'd0, code_unit[11:6]};
            unit_b[2] = ute_pkg::ContMark | {2'd0, code_unit[5:0]};
            unit_cnt  = ute_pkg::CntW'(3);
        end
    end

    // Assemble the burst and the next held state
    always_comb
    begin
        burst           = '0;
        held_valid_next = held_valid_reg;
        held_high_next  = held_high_reg;
        if (pair)
        begin
            burst.bytes[0] = ute_pkg::LeadFour | {5'd0, cp[20:18]};
            burst.bytes[1] = ute_pkg::ContMark | {2'd0, cp[17:12]};
            burst.bytes[2] = ute_pkg::ContMark | {2'd0, cp[11:6]};
            burst.bytes[3] = ute_pkg::ContMark | {2'd0, cp[5:0]};
            burst.cnt      = ute_pkg::CntW'(4);
        end
        else if (held_valid_reg)
        begin
            burst.bytes[0] = held_b[0];
            burst.bytes[1] = held_b[1];
            burst.bytes[2] = held_b[2];
            burst.bytes[3] = unit_b[0];
            burst.bytes[4] = unit_b[1];
            burst.bytes[5] = unit_b[2];
            burst.cnt      = ute_pkg::CntW'(3) + unit_cnt;
        end
        else
        begin
            burst.bytes[0] = unit_b[0];
            burst.bytes[1] = unit_b[1];
            burst.bytes[2] = unit_b[2];
            burst.cnt      = unit_cnt;
        end
        if (take)
        begin
            held_valid_next = unit_hold && !pair;
            held_high_next  = (unit_hold && !pair) ? code_unit : '0;
        end
    end

    // Held surrogate state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            held_high_reg  <= '0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            held_high_reg  <= held_high_next;
        end
    end

    // Only a high surrogate is ever held
    a_held_is_high: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg |-> (held_high_reg >= ute_pkg::HighFirst &&
                            held_high_reg <= ute_pkg::HighLast))
        else $error("held unit is not a high surrogate");

    // A last unit always leaves nothing held
    a_last_flushes: assert property (@(posedge clk) disable iff (!rst_n)
        (take && last_unit) |=> !held_valid_reg)
        else $error("surrogate still held after last unit");

endmodule

// File: sv/ute_serial.sv
// Byte serializer: burst register and output register, one byte per cycle unless stalled.
`timescale 1ns / 1ps

module ute_serial (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  ute_pkg::burst_t burst,
    output logic            busy,
    input  logic            out_stall,
    output logic            out_valid,
    output ute_pkg::byte_t  out_byte,
    output logic            run_end
);

    logic [ute_pkg::BurstMax-1:0][7:0] bytes_reg;
    logic [ute_pkg::CntW-1:0]          cnt_reg;
    logic [ute_pkg::CntW-1:0]          idx_reg;
    logic [ute_pkg::CntW-1:0]          idx_next;
    logic                              busy_reg;
    logic                              busy_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    ute_pkg::byte_t                    out_byte_reg;
    ute_pkg::byte_t                    out_byte_next;
    logic                              run_end_reg;
    logic                              run_end_next;

    logic out_load;
    logic move;
    logic last_move;

    // Output register can take a byte when empty or being drained
    assign out_load  = !out_valid_reg || !out_stall;
    assign move      = busy_reg && out_load;
    assign last_move = move && (idx_reg == (cnt_reg - ute_pkg::CntW'(1)));

    // Burst register frees up as its last byte moves out
    assign busy = busy_reg && !last_move;

    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        run_end_next   = run_end_reg;
        if (out_load)
        begin
            out_valid_next = move;
            out_byte_next  = bytes_reg[idx_reg];
            run_end_next   = last_move;
        end
        if (take)
        begin
            busy_next = (burst.cnt != '0);
            idx_next  = '0;
        end
        else if (last_move)
        begin
            busy_next = 1'b0;
        end
        else if (move)
        begin
            idx_next = idx_reg + ute_pkg::CntW'(1);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                cnt_reg <= burst.cnt;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            bytes_reg <= burst.bytes;
        end
        out_byte_reg <= out_byte_next;
        run_end_reg  <= run_end_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_end   = run_end_reg;

    // Index stays inside the loaded burst
    a_idx_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg < cnt_reg && cnt_reg <= ute_pkg::CntW'(ute_pkg::BurstMax)))
        else $error("burst index out of range");

    // A byte moved out that is not the last advances the index by one
    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        (move && !last_move && !take) |=>
            (busy_reg && idx_reg == ute_pkg::CntW'($past(idx_reg) + 1'b1)))
        else $error("burst index did not advance");

    // The byte that ends a burst is flagged on the output
    a_run_end_mark: assert property (@(posedge clk) disable iff (!rst_n)
        move |=> (out_valid_reg && run_end_reg == $past(last_move)))
        else $error("run end flag mismatch");

endmodule
